>>> rtl/gdc_pkg.sv
// Shared widths, codes and month-length helper for the Gregorian date counter.
`default_nettype none

package gdc_pkg;

  localparam int MODE_W   = 3;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int COUNT_W  = 10;
  localparam int STATUS_W = 2;

  localparam int COUNT_BITS_DEF = 10;

  localparam logic [MODE_W-1:0] MODE_SET  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NEXT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PREV = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ADD  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SUB  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CLAMPED  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SAT      = 2'd3;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0] DAY_28    = 5'd28;
  localparam logic [DAY_W-1:0] DAY_29    = 5'd29;
  localparam logic [DAY_W-1:0] DAY_30    = 5'd30;
  localparam logic [DAY_W-1:0] DAY_31    = 5'd31;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1900;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

  // Result of the leap-year unit.
  typedef struct packed {
    logic done;
    logic leap;
  } leap_res_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      MONTH_FEB:                                len = leap ? DAY_29 : DAY_28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAY_30;
      default:                                  len = DAY_31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> rtl/gdc_in_if.sv
// Input channel of the date counter: mode and operands of one command word.
`default_nettype none

interface gdc_in_if;
  import gdc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [DAY_W-1:0]     new_day;
  logic [MONTH_W-1:0]   new_month;
  logic [YEAR_W-1:0]    new_year;
  logic [COUNT_W-1:0]   day_count;

  modport source (output valid, mode, new_day, new_month, new_year, day_count,
                  input ready);
  modport sink (input valid, mode, new_day, new_month, new_year, day_count,
                output ready);
endinterface

`default_nettype wire

>>> rtl/gdc_out_if.sv
// Result channel of the date counter: current date and status word.
`default_nettype none

interface gdc_out_if;
  import gdc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DAY_W-1:0]     out_day;
  logic [MONTH_W-1:0]   out_month;
  logic [YEAR_W-1:0]    out_year;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, out_day, out_month, out_year, status,
                  input ready);
  modport sink (input valid, out_day, out_month, out_year, status,
                output ready);
endinterface

`default_nettype wire

>>> rtl/gregorian_date_counter_core.sv
// Top level of the Gregorian date counter: command sequencer and month-stepping unit.
//
//   channel   direction  handshake     word
//   in_chan   input      valid/ready   mode, new_day, new_month, new_year, day_count
//   out_chan  output     valid/ready   out_day, out_month, out_year, status
//
// Add and subtract move a whole month per cycle while stepping, pausing for the
// leap-year unit at each year crossed. A set also waits on the leap-year unit.
// Reset (synchronous, active low) loads 1900-01-01. in_chan is ready only while idle;
// a finished result waits in the output register, and a stalled out_chan holds the
// next result back in the final state until the register frees up.
`default_nettype none

module gregorian_date_counter_core #(
  parameter int COUNT_BITS = gdc_pkg::COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gdc_in_if.sink    in_chan,
  gdc_out_if.source out_chan
);
  import gdc_pkg::*;

  localparam int USED_BITS = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
  localparam int W         = (COUNT_BITS > DAY_W + 1) ? COUNT_BITS : DAY_W + 1;

  typedef enum logic [2:0] {ST_IDLE, ST_SET, ST_STEP, ST_LEAP, ST_FIN} state_t;

  state_t                state_r, state_nxt;
  logic [DAY_W-1:0]      day_r, day_nxt;
  logic [MONTH_W-1:0]    month_r, month_nxt;
  logic [YEAR_W-1:0]     year_r, year_nxt;
  logic                  leap_r, leap_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic                  down_r, down_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [DAY_W-1:0]      req_day_r, req_day_nxt;
  logic [MONTH_W-1:0]    req_month_r, req_month_nxt;
  logic [YEAR_W-1:0]     req_year_r, req_year_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DAY_W-1:0]      out_day_r, out_day_nxt;
  logic [MONTH_W-1:0]    out_month_r, out_month_nxt;
  logic [YEAR_W-1:0]     out_year_r, out_year_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  logic                  leap_start;
  logic [YEAR_W-1:0]     leap_year;
  leap_res_t             leap_res;

  logic [DAY_W-1:0]      cur_len;
  logic [DAY_W-1:0]      days_left;
  logic [W-1:0]          rem_w;
  logic                  set_ok;

  gdc_leap_unit u_leap (
    .clk   (clk),
    .rst_n (rst_n),
    .start (leap_start),
    .year  (leap_year),
    .res   (leap_res)
  );

  assign in_chan.ready = (state_r == ST_IDLE);

  assign cur_len   = month_len(month_r, leap_r);
  assign days_left = cur_len - day_r;
  assign rem_w     = W'(rem_r);

  assign set_ok = (req_year_r >= YEAR_MIN) && (req_year_r <= YEAR_MAX) &&
                  (req_month_r >= MONTH_JAN) && (req_month_r <= MONTH_DEC) &&
                  (req_day_r != '0) && (req_day_r <= month_len(req_month_r, leap_res.leap));

  always_comb begin
    state_nxt      = state_r;
    day_nxt        = day_r;
    month_nxt      = month_r;
    year_nxt       = year_r;
    leap_nxt       = leap_r;
    rem_nxt        = rem_r;
    down_nxt       = down_r;
    status_nxt     = status_r;
    req_day_nxt    = req_day_r;
    req_month_nxt  = req_month_r;
    req_year_nxt   = req_year_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_day_nxt    = out_day_r;
    out_month_nxt  = out_month_r;
    out_year_nxt   = out_year_r;
    out_status_nxt = out_status_r;
    leap_start     = 1'b0;
    leap_year      = year_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          status_nxt    = STATUS_OK;
          req_day_nxt   = in_chan.new_day;
          req_month_nxt = in_chan.new_month;
          req_year_nxt  = in_chan.new_year;
          rem_nxt       = COUNT_BITS'(in_chan.day_count[USED_BITS-1:0]);
          down_nxt      = 1'b0;
          case (in_chan.mode)
            MODE_SET: begin
              leap_start = 1'b1;
              leap_year  = in_chan.new_year;
              state_nxt  = ST_SET;
            end
            MODE_NEXT: begin
              rem_nxt   = COUNT_BITS'(1);
              state_nxt = ST_STEP;
            end
            MODE_PREV: begin
              rem_nxt   = COUNT_BITS'(1);
              down_nxt  = 1'b1;
              state_nxt = ST_STEP;
            end
            MODE_ADD: begin
              state_nxt = ST_STEP;
            end
            MODE_SUB: begin
              down_nxt  = 1'b1;
              state_nxt = ST_STEP;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      ST_SET: begin
        if (leap_res.done) begin
          if (set_ok) begin
            day_nxt   = req_day_r;
            month_nxt = req_month_r;
            year_nxt  = req_year_r;
            leap_nxt  = leap_res.leap;
          end else begin
            status_nxt = STATUS_REJECTED;
          end
          state_nxt = ST_FIN;
        end
      end

      ST_STEP: begin
        if (!down_r) begin
          if (rem_w <= W'(days_left)) begin
            day_nxt   = day_r + rem_w[DAY_W-1:0];
            state_nxt = ST_FIN;
          end else begin
            // Jump to the first day of the next month.
            rem_nxt = COUNT_BITS'(rem_w - W'(days_left) - W'(1));
            day_nxt = DAY_FIRST;
            if (month_r == MONTH_DEC) begin
              if (year_r == YEAR_MAX) begin
                day_nxt    = DAY_31;
                status_nxt = STATUS_SAT;
                state_nxt  = ST_FIN;
              end else begin
                month_nxt  = MONTH_JAN;
                year_nxt   = year_r + YEAR_W'(1);
                leap_start = 1'b1;
                leap_year  = year_nxt;
                state_nxt  = ST_LEAP;
              end
            end else begin
              month_nxt = month_r + MONTH_W'(1);
            end
          end
        end else begin
          if (rem_w < W'(day_r)) begin
            day_nxt   = day_r - rem_w[DAY_W-1:0];
            state_nxt = ST_FIN;
          end else begin
            // Jump to the last day of the previous month.
            rem_nxt = COUNT_BITS'(rem_w - W'(day_r));
            if (month_r != MONTH_JAN) begin
              month_nxt = month_r - MONTH_W'(1);
              day_nxt   = month_len(month_nxt, leap_r);
            end else if (year_r == YEAR_MIN) begin
              day_nxt    = DAY_FIRST;
              status_nxt = STATUS_CLAMPED;
              state_nxt  = ST_FIN;
            end else begin
              month_nxt  = MONTH_DEC;
              day_nxt    = DAY_31;
              year_nxt   = year_r - YEAR_W'(1);
              leap_start = 1'b1;
              leap_year  = year_nxt;
              state_nxt  = ST_LEAP;
            end
          end
        end
      end

      ST_LEAP: begin
        if (leap_res.done) begin
          leap_nxt  = leap_res.leap;
          state_nxt = ST_STEP;
        end
      end

      ST_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_day_nxt    = day_r;
          out_month_nxt  = month_r;
          out_year_nxt   = year_r;
          out_status_nxt = status_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      day_r       <= DAY_FIRST;
      month_r     <= MONTH_JAN;
      year_r      <= YEAR_MIN;
      leap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      leap_r      <= leap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r        <= rem_nxt;
    down_r       <= down_nxt;
    status_r     <= status_nxt;
    req_day_r    <= req_day_nxt;
    req_month_r  <= req_month_nxt;
    req_year_r   <= req_year_nxt;
    out_day_r    <= out_day_nxt;
    out_month_r  <= out_month_nxt;
    out_year_r   <= out_year_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_day   = out_day_r;
  assign out_chan.out_month = out_month_r;
  assign out_chan.out_year  = out_year_r;
  assign out_chan.status    = out_status_r;

endmodule

`default_nettype wire

>>> rtl/gdc_leap_unit.sv
// Two-stage leap-year unit: divides the year by 100 through a reciprocal multiply.
`default_nettype none

module gdc_leap_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gdc_pkg::YEAR_W-1:0] year,
  output gdc_pkg::leap_res_t         res
);
  import gdc_pkg::*;

  // 5243 / 2^19 is close enough to 1/100 that the quotient is exact for all 14-bit years.
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int PROD_W      = YEAR_W + RECIP_W;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;
  localparam logic [YEAR_W-1:0] HUNDRED = 14'd100;

  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q_r;
  logic [YEAR_W-1:0] year_r;
  logic [YEAR_W-1:0] rem100;
  logic              s1_valid_r;
  logic              done_r;
  logic              leap_r;

  assign prod   = PROD_W'(year) * PROD_W'(RECIP_100);
  assign rem100 = year_r - YEAR_W'(q_r) * HUNDRED;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      s1_valid_r <= start;
      done_r     <= s1_valid_r;
    end
    q_r    <= prod[PROD_W-1:RECIP_SHIFT];
    year_r <= year;
    // A century year is leap only when the century count is a multiple of four.
    leap_r <= (rem100 == '0) ? (q_r[1:0] == 2'b00) : (year_r[1:0] == 2'b00);
  end

  assign res.done = done_r;
  assign res.leap = leap_r;

endmodule

`default_nettype wire
